// ----- hdl/hcbd_pkg.sv -----
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types, character codes and the hex digit decoder used by the chunked
// body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  // Progress through the number on a chunk size line.
  typedef enum logic [1:0] {
    NS_NONE   = 2'd0,
    NS_ZERO   = 2'd1,
    NS_DIGITS = 2'd2,
    NS_CLOSED = 2'd3
  } num_stage_e;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LC_X  = 8'h78;
  localparam logic [7:0] CHAR_UC_X  = 8'h58;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] b);
    hex_digit_t r;
    r.valid = 1'b1;
    r.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r.value = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r.value = 4'(b - 8'h37);
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- hdl/http_chunked_body_decoder_core.sv -----
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// Strips HTTP/1.1 chunked transfer framing from a byte stream and passes on
// the payload bytes, with one end-of-body item after the zero-size chunk.
// ----------------------------------------------------------------------------
//  Channel | Ports                                 | Direction
//  --------+---------------------------------------+----------
//  in      | in_valid_i, in_stall_o, in_byte_i     | into core
//  out     | out_valid_o, out_stall_i, out_byte_o, | out of core
//          | body_end_o                            |
//
// One byte is accepted per cycle; its result, if any, appears in the output
// register on the next cycle. The decoder state and the output register are
// updated in the same edge, so the rate is limited only by the output side.
// in_stall_o is high only while the output register holds an item that the
// receiver is stalling. Reset is asynchronous and returns the core to the
// start of a size line with the output register empty.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core import hcbd_pkg::*; #(
  parameter int SIZE_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       body_end_o
);

  typedef enum logic [1:0] {
    PH_LINE = 2'd0,
    PH_DATA = 2'd1,
    PH_SKIP = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  phase_e               phase_q;
  num_stage_e           stage_q;
  logic                 cr_seen_q;
  logic [SIZE_BITS-1:0] size_q;
  logic [SIZE_BITS-1:0] remain_q;
  logic [1:0]           skip_q;
  logic                 out_valid_q;
  logic [7:0]           out_byte_q;
  logic                 body_end_q;

  logic                 in_acc;
  logic                 is_cr;
  logic                 is_lf;
  num_stage_e           stage_eff;
  num_stage_e           stage_d;
  logic [SIZE_BITS-1:0] size_d;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign is_cr      = (in_byte_i == CHAR_CR);
  assign is_lf      = (in_byte_i == CHAR_LF);

  // A CR that is not followed by LF is an ordinary non-hex character, which
  // always closes the number.
  assign stage_eff = cr_seen_q ? NS_CLOSED : stage_q;

  hcbd_line_parse #(
    .SIZE_BITS(SIZE_BITS)
  ) u_line_parse (
    .byte_i (in_byte_i),
    .stage_i(stage_eff),
    .size_i (size_q),
    .stage_o(stage_d),
    .size_o (size_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LINE;
      stage_q     <= NS_NONE;
      cr_seen_q   <= 1'b0;
      size_q      <= '0;
      remain_q    <= '0;
      skip_q      <= 2'd0;
      out_valid_q <= 1'b0;
      out_byte_q  <= 8'd0;
      body_end_q  <= 1'b0;
    end else begin
      if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc) begin
        unique case (phase_q)
          PH_LINE: begin
            if (cr_seen_q && is_lf) begin
              cr_seen_q <= 1'b0;
              if (size_q == '0) begin
                phase_q     <= PH_DONE;
                out_valid_q <= 1'b1;
                out_byte_q  <= 8'd0;
                body_end_q  <= 1'b1;
              end else begin
                remain_q <= size_q;
                phase_q  <= PH_DATA;
              end
            end else if (is_cr) begin
              cr_seen_q <= 1'b1;
              stage_q   <= stage_eff;
            end else begin
              cr_seen_q <= 1'b0;
              stage_q   <= stage_d;
              size_q    <= size_d;
            end
          end
          PH_DATA: begin
            out_valid_q <= 1'b1;
            out_byte_q  <= in_byte_i;
            body_end_q  <= 1'b0;
            remain_q    <= remain_q - SIZE_BITS'(1);
            if (remain_q == SIZE_BITS'(1)) begin
              phase_q <= PH_SKIP;
              skip_q  <= 2'd2;
            end
          end
          PH_SKIP: begin
            skip_q <= skip_q - 2'd1;
            if (skip_q == 2'd1) begin
              phase_q   <= PH_LINE;
              stage_q   <= NS_NONE;
              cr_seen_q <= 1'b0;
              size_q    <= '0;
            end
          end
          default: begin
            phase_q <= PH_DONE;
          end
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign body_end_o  = body_end_q;

  a_done_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE |=> phase_q == PH_DONE)
    else $error("decoder left the finished phase");

  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> remain_q != '0)
    else $error("payload phase with no bytes remaining");

  a_skip_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SKIP |-> (skip_q == 2'd1 || skip_q == 2'd2))
    else $error("trailing skip count out of range");

  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && body_end_q |-> out_byte_q == 8'd0 && phase_q == PH_DONE)
    else $error("end-of-body item carries data or phase is wrong");

endmodule

// ----- hdl/hcbd_line_parse.sv -----
// ----------------------------------------------------------------------------
// hcbd_line_parse
// Next-state logic for the number on a chunk size line: skips leading blanks,
// accepts a 0x prefix and accumulates hex digits with saturation.
// ----------------------------------------------------------------------------
module hcbd_line_parse import hcbd_pkg::*; #(
  parameter int SIZE_BITS = 32
) (
  input  logic [7:0]           byte_i,
  input  num_stage_e           stage_i,
  input  logic [SIZE_BITS-1:0] size_i,
  output num_stage_e           stage_o,
  output logic [SIZE_BITS-1:0] size_o
);

  hex_digit_t           hex;
  logic                 blank;
  logic                 is_x;
  logic [SIZE_BITS-1:0] size_acc;

  assign hex   = hex_decode(byte_i);
  assign blank = (byte_i == CHAR_SPACE) || (byte_i == CHAR_TAB);
  assign is_x  = (byte_i == CHAR_LC_X) || (byte_i == CHAR_UC_X);

  // Once the top nibble is in use another digit would overflow, so the size
  // sticks at all ones.
  always_comb begin
    if (size_i[SIZE_BITS-1 -: 4] != 4'd0) begin
      size_acc = '1;
    end else begin
      size_acc = {size_i[SIZE_BITS-5:0], hex.value};
    end
  end

  always_comb begin
    stage_o = stage_i;
    size_o  = size_i;
    unique case (stage_i)
      NS_NONE: begin
        if (!blank) begin
          if (hex.valid && hex.value == 4'd0) begin
            stage_o = NS_ZERO;
          end else if (hex.valid) begin
            size_o  = size_acc;
            stage_o = NS_DIGITS;
          end else begin
            stage_o = NS_CLOSED;
          end
        end
      end
      NS_ZERO: begin
        if (is_x) begin
          stage_o = NS_DIGITS;
        end else if (hex.valid) begin
          size_o  = size_acc;
          stage_o = NS_DIGITS;
        end else begin
          stage_o = NS_CLOSED;
        end
      end
      NS_DIGITS: begin
        if (hex.valid) begin
          size_o = size_acc;
        end else begin
          stage_o = NS_CLOSED;
        end
      end
      default: begin
        stage_o = stage_i;
      end
    endcase
  end

endmodule
